FILE: rtl/uae_pkg.sv
// Shared types and constants for the unordered array engine.
// Command and result beat layouts, opcodes, status codes, cell actions.
// No dependencies.
package uae_pkg;

  // Fixed field widths of the command and result beats
  localparam int OP_W  = 4;
  localparam int IDX_W = 7;
  localparam int ST_W  = 3;

  typedef logic signed [31:0] word_t;

  // Opcodes
  localparam logic [OP_W-1:0] OP_DUMP  = 4'd0;
  localparam logic [OP_W-1:0] OP_APP   = 4'd1;
  localparam logic [OP_W-1:0] OP_INSAT = 4'd2;
  localparam logic [OP_W-1:0] OP_BMAX  = 4'd3;
  localparam logic [OP_W-1:0] OP_AMIN  = 4'd4;
  localparam logic [OP_W-1:0] OP_SRCH  = 4'd5;
  localparam logic [OP_W-1:0] OP_MXMN  = 4'd6;
  localparam logic [OP_W-1:0] OP_CNT   = 4'd7;
  localparam logic [OP_W-1:0] OP_DEL   = 4'd8;
  localparam logic [OP_W-1:0] OP_D2MAX = 4'd9;
  localparam logic [OP_W-1:0] OP_DKMIN = 4'd10;
  localparam logic [OP_W-1:0] OP_DDUP  = 4'd11;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFND = 3'd4;
  localparam logic [ST_W-1:0] ST_BADK   = 3'd5;

  // Cell actions
  localparam logic [2:0] ACT_HOLD = 3'd0;
  localparam logic [2:0] ACT_ROT  = 3'd1;
  localparam logic [2:0] ACT_INS  = 3'd2;
  localparam logic [2:0] ACT_DEL  = 3'd3;
  localparam logic [2:0] ACT_CLR  = 3'd4;
  localparam logic [2:0] ACT_MARK = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    word_t            value;
    logic [IDX_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] index;
    word_t            value_res;
    logic [IDX_W-1:0] min_index;
    word_t            min_value;
    logic [IDX_W-1:0] count;
    logic             last;
  } res_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic [2:0] act;
    word_t      value;
  } cell_ctl_t;

endpackage

FILE: rtl/uae_cmd_if.sv
// Command channel interface: valid/ready handshake with a cmd_t payload.
// Depends on uae_pkg.
interface uae_cmd_if import uae_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/uae_res_if.sv
// Result channel interface: valid/ready handshake with a res_t payload.
// Depends on uae_pkg.
interface uae_res_if import uae_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/uae_cell.sv
// One storage cell of the entry ring: a word plus its exclusion flag.
// Shifts left/right for delete/insert and rotates toward cell 0 on scans.
// Depends on uae_pkg.
module uae_cell import uae_pkg::*; #(
  parameter int AW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic [AW-1:0] pos,
  input  word_t         left_data,
  input  logic          left_mask,
  input  word_t         right_data,
  input  logic          right_mask,
  output word_t         data,
  output logic          mask
);

  logic at_pos, above_pos;

  assign at_pos    = pos == AW'(IDX);
  assign above_pos = AW'(IDX) > pos;

  // Word register
  always_ff @(posedge clk) begin
    unique case (ctl.act)
      ACT_ROT: data <= right_data;
      ACT_INS: begin
        if (above_pos) data <= left_data;
        else if (at_pos) data <= ctl.value;
      end
      ACT_DEL: if (above_pos || at_pos) data <= right_data;
      default: ;
    endcase
  end

  // Exclusion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 1'b0;
    end else begin
      unique case (ctl.act)
        ACT_ROT:  mask <= right_mask;
        ACT_INS: begin
          if (above_pos) mask <= left_mask;
          else if (at_pos) mask <= 1'b0;
        end
        ACT_DEL:  if (above_pos || at_pos) mask <= right_mask;
        ACT_CLR:  mask <= 1'b0;
        ACT_MARK: if (at_pos) mask <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/unordered_array_engine.sv
// Unordered array engine top level: command sequencer around a ring of cells.
// Depends on uae_pkg, uae_cmd_if, uae_res_if, uae_cell.
//
// Use: commands arrive on cmd (op, value, position); results leave on res, one
// beat per result, the final beat of a command carrying last. A command is taken
// only while the sequencer is idle; an earlier result may still sit in the output
// register at that time.
// Entries live in a ring of DEPTH cells. A scan rotates the ring one cell per
// cycle unless a stalled result beat holds it, so cell 0 shows entry t at scan
// step t; a full scan steps through all DEPTH cells and leaves the order intact.
// Insert and delete shift the row. Steps per command: errors found up front go
//   straight to the output register; append and insert at position shift the
//   row; search, max/min, delete value, before-max and after-min make one scan,
//   then act; dump emits a beat per entry during its scan; list matches counts
//   in one scan and, if any match, emits a beat per match in a second; delete
//   kth minimum and delete second max scan once per extreme, excluding each,
//   then delete the last; dedupe scans once per entry to flag later duplicates,
//   then once per flagged entry to delete it and once more to find none left.
// Reset clears the entry count and the output valid flag; entry words are not
// cleared. A stalled receiver freezes dump and list scans at the current beat;
// other commands wait with their single result until it is taken.
module unordered_array_engine import uae_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  uae_cmd_if.sink   cmd,
  uae_res_if.source res
);

  localparam int TW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_EDIT  = 3'd6;
  localparam logic [2:0] S_PUT   = 3'd7;

  logic [2:0]       st;
  logic [OP_W-1:0]  op_r;
  word_t            val_r;
  logic [CW-1:0]    count;
  logic [TW-1:0]    t;
  logic [CW-1:0]    np;
  logic [CW-1:0]    nk;
  logic             phase;
  logic             hit;
  logic [TW-1:0]    hidx;
  logic [CW-1:0]    mcnt;
  logic [CW-1:0]    k;
  logic             mxh, mnh;
  logic [TW-1:0]    mxi, mni;
  word_t            mxv, mnv;
  word_t            ddv;
  word_t            ev;
  logic [TW-1:0]    pos_r;
  logic             edit_ins;
  res_t             pend;
  logic             out_valid;
  res_t             out_data;

  word_t     cell_data [DEPTH];
  logic      cell_mask [DEPTH];
  cell_ctl_t ctl;

  word_t hd;
  logic  hm, hv, eq, cond, is_dd, use_mask, en, emit, go, out_free, t_end, mark_head;
  res_t  emit_data;

  function automatic res_t fail_res(input logic [ST_W-1:0] s, input logic [IDX_W-1:0] c);
    res_t r;
    r = '{status: s, index: '0, value_res: '0, min_index: '0, min_value: '0,
          count: c, last: 1'b1};
    return r;
  endfunction

  assign cmd.ready = st == S_IDLE;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  // Head-of-ring view during a scan
  assign hd       = cell_data[0];
  assign hm       = cell_mask[0];
  assign hv       = CW'(t) < count;
  assign eq       = hd == val_r;
  assign is_dd    = op_r == OP_DDUP;
  assign cond     = is_dd ? hm : eq;
  assign use_mask = (op_r == OP_D2MAX) || (op_r == OP_DKMIN);
  assign en       = hv && !(use_mask && hm);
  assign t_end    = t == TW'(DEPTH - 1);
  assign out_free = !out_valid || res.ready;
  assign emit     = (st == S_SCAN) && hv &&
                    ((op_r == OP_DUMP) || ((op_r == OP_CNT) && phase && eq));
  assign go       = !emit || out_free;
  assign mark_head = (st == S_SCAN) && go && is_dd && !phase && hv &&
                     (CW'(t) > np) && (hd == ddv);

  // Beat produced while scanning (dump or match listing)
  always_comb begin
    if (op_r == OP_DUMP) begin
      emit_data = '{status: ST_OK, index: IDX_W'(t), value_res: hd, min_index: '0,
                    min_value: '0, count: IDX_W'(count),
                    last: (CW'(t) + CW'(1)) == count};
    end else begin
      emit_data = '{status: ST_OK, index: IDX_W'(t), value_res: val_r, min_index: '0,
                    min_value: '0, count: IDX_W'(mcnt), last: (k + CW'(1)) == mcnt};
    end
  end

  // Cell action for this cycle
  always_comb begin
    ctl.value = val_r;
    unique case (st)
      S_SCAN:  ctl.act = go ? ACT_ROT : ACT_HOLD;
      S_CLR:   ctl.act = ACT_CLR;
      S_MARK:  ctl.act = ACT_MARK;
      S_EDIT:  ctl.act = edit_ins ? ACT_INS : ACT_DEL;
      default: ctl.act = ACT_HOLD;
    endcase
  end

  // Ring of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int R = (g + 1) % DEPTH;
    word_t ld;
    logic  lm, rm;
    if (g == 0) begin : g_first
      assign ld = '0;
      assign lm = 1'b0;
    end else begin : g_rest
      assign ld = cell_data[g-1];
      assign lm = cell_mask[g-1];
    end
    if (g == DEPTH - 1) begin : g_wrap
      assign rm = cell_mask[R] | mark_head;
    end else begin : g_mid
      assign rm = cell_mask[R];
    end
    uae_cell #(.AW(TW), .IDX(g)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pos        (pos_r),
      .left_data  (ld),
      .left_mask  (lm),
      .right_data (cell_data[R]),
      .right_mask (rm),
      .data       (cell_data[g]),
      .mask       (cell_mask[g])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (emit && go) begin
        out_valid <= 1'b1;
        out_data  <= emit_data;
      end else if ((st == S_PUT) && out_free) begin
        out_valid <= 1'b1;
        out_data  <= pend;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (cmd.valid) begin
            op_r   <= cmd.data.op;
            val_r  <= cmd.data.value;
            phase  <= 1'b0;
            np     <= '0;
            mcnt   <= '0;
            k      <= '0;
            unique case (cmd.data.op)
              OP_DUMP: begin
                if (count == '0) begin
                  pend <= fail_res(ST_EMPTY, IDX_W'(count));
                  st   <= S_PUT;
                end else st <= S_START;
              end
              OP_APP: begin
                if (count == CW'(DEPTH)) begin
                  pend <= fail_res(ST_FULL, IDX_W'(count));
                  st   <= S_PUT;
                end else begin
                  pos_r    <= TW'(count);
                  edit_ins <= 1'b1;
                  st       <= S_EDIT;
                end
              end
              OP_INSAT: begin
                if (count == CW'(DEPTH)) begin
                  pend <= fail_res(ST_FULL, IDX_W'(count));
                  st   <= S_PUT;
                end else if (int'(cmd.data.position) > int'(count)) begin
                  pend <= fail_res(ST_BADPOS, IDX_W'(count));
                  st   <= S_PUT;
                end else begin
                  pos_r    <= TW'(cmd.data.position);
                  edit_ins <= 1'b1;
                  st       <= S_EDIT;
                end
              end
              OP_BMAX, OP_AMIN: begin
                if (count == CW'(DEPTH)) begin
                  pend <= fail_res(ST_FULL, IDX_W'(count));
                  st   <= S_PUT;
                end else if (count == '0) begin
                  pend <= fail_res(ST_EMPTY, IDX_W'(count));
                  st   <= S_PUT;
                end else st <= S_START;
              end
              OP_SRCH, OP_DEL, OP_CNT: st <= S_START;
              OP_MXMN: begin
                if (count == '0) begin
                  pend <= fail_res(ST_EMPTY, IDX_W'(count));
                  st   <= S_PUT;
                end else st <= S_START;
              end
              OP_D2MAX: begin
                if (count == '0) begin
                  pend <= fail_res(ST_EMPTY, IDX_W'(count));
                  st   <= S_PUT;
                end else if (count == CW'(1)) begin
                  pend <= fail_res(ST_BADK, IDX_W'(count));
                  st   <= S_PUT;
                end else begin
                  nk <= CW'(2);
                  st <= S_CLR;
                end
              end
              OP_DKMIN: begin
                if (count == '0) begin
                  pend <= fail_res(ST_EMPTY, IDX_W'(count));
                  st   <= S_PUT;
                end else if ((cmd.data.position == '0) ||
                             (int'(cmd.data.position) > int'(count))) begin
                  pend <= fail_res(ST_BADK, IDX_W'(count));
                  st   <= S_PUT;
                end else begin
                  nk <= CW'(cmd.data.position);
                  st <= S_CLR;
                end
              end
              OP_DDUP: begin
                phase <= count == '0;
                st    <= S_CLR;
              end
              default: ;
            endcase
          end
        end

        // Pass setup: clear accumulators (S_CLR also clears exclusion flags)
        S_CLR, S_START: begin
          t   <= '0;
          hit <= 1'b0;
          mxh <= 1'b0;
          mnh <= 1'b0;
          st  <= S_SCAN;
        end

        // One entry per cycle past cell 0, unless a stalled result beat holds the scan
        S_SCAN: begin
          if (go) begin
            if (hv && cond && !hit) begin
              hit  <= 1'b1;
              hidx <= t;
            end
            if (hv && eq && !phase) mcnt <= mcnt + CW'(1);
            if (en && (!mxh || hd > mxv)) begin
              mxh <= 1'b1;
              mxi <= t;
              mxv <= hd;
            end
            if (en && (!mnh || hd < mnv)) begin
              mnh <= 1'b1;
              mni <= t;
              mnv <= hd;
            end
            if (is_dd && (CW'(t) == np)) ddv <= hd;
            if (emit) k <= k + CW'(1);
            t <= t + TW'(1);
            if (t_end) st <= S_END;
          end
        end

        // Act on what the pass found
        S_END: begin
          unique case (op_r)
            OP_BMAX: begin
              pos_r    <= mxi;
              edit_ins <= 1'b1;
              st       <= S_EDIT;
            end
            OP_AMIN: begin
              pos_r    <= mni + TW'(1);
              edit_ins <= 1'b1;
              st       <= S_EDIT;
            end
            OP_SRCH: begin
              if (hit) begin
                pend <= '{status: ST_OK, index: IDX_W'(hidx), value_res: val_r,
                          min_index: '0, min_value: '0, count: IDX_W'(count), last: 1'b1};
              end else begin
                pend <= fail_res(ST_NOTFND, IDX_W'(count));
              end
              st <= S_PUT;
            end
            OP_DEL: begin
              if (hit) begin
                pos_r    <= hidx;
                ev       <= val_r;
                edit_ins <= 1'b0;
                st       <= S_EDIT;
              end else begin
                pend <= fail_res(ST_NOTFND, IDX_W'(count));
                st   <= S_PUT;
              end
            end
            OP_MXMN: begin
              pend <= '{status: ST_OK, index: IDX_W'(mxi), value_res: mxv,
                        min_index: IDX_W'(mni), min_value: mnv,
                        count: IDX_W'(count), last: 1'b1};
              st   <= S_PUT;
            end
            OP_CNT: begin
              if (phase) begin
                st <= S_IDLE;
              end else if (mcnt == '0) begin
                pend <= '{status: ST_OK, index: '0, value_res: val_r, min_index: '0,
                          min_value: '0, count: '0, last: 1'b1};
                st   <= S_PUT;
              end else begin
                phase <= 1'b1;
                st    <= S_START;
              end
            end
            OP_D2MAX: begin
              pos_r <= mxi;
              ev    <= mxv;
              st    <= S_MARK;
            end
            OP_DKMIN: begin
              pos_r <= mni;
              ev    <= mnv;
              st    <= S_MARK;
            end
            OP_DDUP: begin
              if (!phase) begin
                if ((np + CW'(1)) == count) phase <= 1'b1;
                np <= np + CW'(1);
                st <= S_START;
              end else if (hit) begin
                pos_r    <= hidx;
                edit_ins <= 1'b0;
                st       <= S_EDIT;
              end else begin
                pend <= '{status: ST_OK, index: '0, value_res: '0, min_index: '0,
                          min_value: '0, count: IDX_W'(count), last: 1'b1};
                st   <= S_PUT;
              end
            end
            default: st <= S_IDLE;
          endcase
        end

        // Exclude the extreme just found; repeat until k found
        S_MARK: begin
          np <= np + CW'(1);
          if ((np + CW'(1)) == nk) begin
            edit_ins <= 1'b0;
            st       <= S_EDIT;
          end else begin
            st <= S_START;
          end
        end

        // Shift the row for insert or delete
        S_EDIT: begin
          if (edit_ins) begin
            count <= count + CW'(1);
            pend  <= '{status: ST_OK, index: IDX_W'(pos_r), value_res: val_r,
                       min_index: '0, min_value: '0,
                       count: IDX_W'(count + CW'(1)), last: 1'b1};
          end else begin
            count <= count - CW'(1);
            pend  <= '{status: ST_OK, index: IDX_W'(pos_r), value_res: ev,
                       min_index: '0, min_value: '0,
                       count: IDX_W'(count - CW'(1)), last: 1'b1};
          end
          st <= is_dd ? S_START : S_PUT;
        end

        S_PUT: if (out_free) st <= S_IDLE;

        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/uae_chk.sv
// Port-level checker for the unordered array engine, bound to the top level.
// Depends on uae_pkg and unordered_array_engine.
module uae_chk import uae_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // A stalled result beat stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_data))
    else $error("result payload changed while stalled");

  // Error results are always single, final beats
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status != ST_OK) |-> res_data.last)
    else $error("error result without last");

  // Nothing but successful beats precede a final beat
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.last |-> (res_data.status == ST_OK) &&
      (res_data.min_index == '0) && (res_data.min_value == '0))
    else $error("bad intermediate result beat");

endmodule

bind unordered_array_engine uae_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

FILE: verif/tb_unordered_array_engine.sv
// Self-checking testbench for the unordered array engine.
// Depends on uae_pkg, uae_cmd_if, uae_res_if and the engine RTL.
module tb_unordered_array_engine;
  import uae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   idle_cycles = 0;

  uae_cmd_if cmd ();
  uae_res_if res ();

  unordered_array_engine #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Array model plus queue of pending result beats
  class array_scoreboard;
    word_t store[DEPTH];
    int    held;
    res_t  pending[$];

    function void push(logic [2:0] st, int idx, word_t v, int midx, word_t mv,
                       int cnt, bit lst);
      res_t r;
      r.status = st; r.index = IDX_W'(idx); r.value_res = v;
      r.min_index = IDX_W'(midx);
      r.min_value = mv; r.count = IDX_W'(cnt); r.last = lst;
      pending.push_back(r);
    endfunction

    function void shift_in(int p, word_t v);
      for (int i = held; i > p; i--) store[i] = store[i-1];
      store[p] = v;
      held++;
    endfunction

    function void shift_out(int p);
      for (int i = p; i + 1 < held; i++) store[i] = store[i+1];
      held--;
    endfunction

    // First max or min among entries not excluded; -1 when none
    function int first_extreme(bit want_max, bit excl[DEPTH]);
      int pos;
      pos = -1;
      for (int i = 0; i < held; i++) begin
        if (excl[i]) continue;
        if (pos < 0 || (want_max ? store[i] > store[pos] : store[i] < store[pos]))
          pos = i;
      end
      return pos;
    endfunction

    // Predict the result beats of one accepted command
    function void note_command(cmd_t c);
      bit    none[DEPTH];
      bit    excl[DEPTH];
      int    p, q, n, k;
      word_t v;
      foreach (none[i]) none[i] = 1'b0;
      case (c.op)
        OP_DUMP: begin
          if (held == 0) push(ST_EMPTY, 0, 0, 0, 0, 0, 1);
          else for (int i = 0; i < held; i++)
            push(ST_OK, i, store[i], 0, 0, held, i + 1 == held);
        end
        OP_APP, OP_INSAT, OP_BMAX, OP_AMIN: begin
          if (held >= DEPTH) begin push(ST_FULL, 0, 0, 0, 0, held, 1); return; end
          if (c.op == OP_APP) p = held;
          else if (c.op == OP_INSAT) begin
            if (int'(c.position) > held) begin
              push(ST_BADPOS, 0, 0, 0, 0, held, 1);
              return;
            end
            p = int'(c.position);
          end else begin
            p = first_extreme(c.op == OP_BMAX, none);
            if (p < 0) begin push(ST_EMPTY, 0, 0, 0, 0, held, 1); return; end
            if (c.op == OP_AMIN) p++;
          end
          shift_in(p, c.value);
          push(ST_OK, p, c.value, 0, 0, held, 1);
        end
        OP_SRCH, OP_DEL: begin
          p = -1;
          for (int i = 0; i < held; i++) if (p < 0 && store[i] == c.value) p = i;
          if (p < 0) begin push(ST_NOTFND, 0, 0, 0, 0, held, 1); return; end
          if (c.op == OP_DEL) shift_out(p);
          push(ST_OK, p, c.value, 0, 0, held, 1);
        end
        OP_MXMN: begin
          p = first_extreme(1'b1, none);
          if (p < 0) begin push(ST_EMPTY, 0, 0, 0, 0, held, 1); return; end
          q = first_extreme(1'b0, none);
          push(ST_OK, p, store[p], q, store[q], held, 1);
        end
        OP_CNT: begin
          n = 0;
          for (int i = 0; i < held; i++) if (store[i] == c.value) n++;
          if (n == 0) push(ST_OK, 0, c.value, 0, 0, 0, 1);
          k = 0;
          for (int i = 0; i < held; i++) if (store[i] == c.value) begin
            k++;
            push(ST_OK, i, c.value, 0, 0, n, k == n);
          end
        end
        OP_D2MAX, OP_DKMIN: begin
          if (held == 0) begin push(ST_EMPTY, 0, 0, 0, 0, 0, 1); return; end
          n = (c.op == OP_D2MAX) ? 2 : int'(c.position);
          if (n == 0 || n > held) begin push(ST_BADK, 0, 0, 0, 0, held, 1); return; end
          foreach (excl[i]) excl[i] = 1'b0;
          for (int i = 0; i < n; i++) begin
            p = first_extreme(c.op == OP_D2MAX, excl);
            excl[p] = 1'b1;
          end
          v = store[p];
          shift_out(p);
          push(ST_OK, p, v, 0, 0, held, 1);
        end
        OP_DDUP: begin
          for (int i = 0; i < held; i++) begin
            q = i + 1;
            while (q < held) if (store[q] == store[i]) shift_out(q); else q++;
          end
          push(ST_OK, 0, 0, 0, 0, held, 1);
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat against the oldest prediction
    task check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.index !== e.index)
        report($sformatf("index got %0d exp %0d", got.index, e.index));
      if (got.value_res !== e.value_res)
        report($sformatf("value_res got %0d exp %0d", got.value_res, e.value_res));
      if (got.min_index !== e.min_index)
        report($sformatf("min_index got %0d exp %0d", got.min_index, e.min_index));
      if (got.min_value !== e.min_value)
        report($sformatf("min_value got %0d exp %0d", got.min_value, e.min_value));
      if (got.count !== e.count)
        report($sformatf("count got %0d exp %0d", got.count, e.count));
      if (got.last !== e.last)
        report($sformatf("last got %0d exp %0d", got.last, e.last));
    endtask
  endclass

  array_scoreboard sb = new();

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready) sb.note_command(cmd.data);
      if (res.valid && res.ready) sb.check_result(res.data);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts
  initial begin
    int g;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        res.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send(logic [3:0] op, word_t v, logic [6:0] pos);
    int g;
    g = gap_len();
    if (g > 0) begin
      cmd.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data.op <= op;
    cmd.data.value <= v;
    cmd.data.position <= pos;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 7)) - 3;
    endcase
  endfunction

  // Insert-heavy mix while the store is small keeps it populated
  function automatic logic [3:0] pick_op(int held);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 4'($urandom_range(12, 15));
    if (held < 6 && r < 60) return 4'($urandom_range(1, 4));
    if (r < 35) return 4'($urandom_range(1, 4));
    if (r < 40) return OP_DUMP;
    if (r < 45) return OP_DDUP;
    return 4'($urandom_range(5, 10));
  endfunction

  initial begin
    logic [3:0] op;
    logic [6:0] pos;
    cmd.valid <= 1'b0;
    cmd.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store errors, then extremes and ties
    send(OP_DUMP, 0, 0);
    send(OP_BMAX, 1, 0);
    send(OP_AMIN, 1, 0);
    send(OP_MXMN, 0, 0);
    send(OP_D2MAX, 0, 0);
    send(OP_DKMIN, 0, 1);
    send(OP_SRCH, 5, 0);
    send(OP_DEL, 5, 0);
    send(OP_CNT, 5, 0);
    send(OP_DDUP, 0, 0);
    send(OP_INSAT, 9, 1);
    send(OP_APP, 32'sh7fffffff, 0);
    send(OP_D2MAX, 0, 0);
    send(OP_INSAT, 32'sh80000000, 0);
    send(OP_BMAX, 32'sh7fffffff, 0);
    send(OP_AMIN, 32'sh80000000, 0);
    send(OP_MXMN, 0, 0);
    send(OP_CNT, 32'sh7fffffff, 0);
    send(OP_D2MAX, 0, 0);
    send(OP_DKMIN, 0, 0);
    send(OP_DKMIN, 0, 7'd64);
    send(OP_DKMIN, 0, 2);
    send(OP_DDUP, 0, 0);
    send(4'd15, 0, 0);
    send(OP_DUMP, 0, 0);

    // Random: mostly valid positions, some out of range
    for (int n = 0; n < 190; n++) begin
      op = pick_op(sb.held);
      if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
      else pos = 7'($urandom_range(0, sb.held + 1));
      send(op, pick_value(), pos);
      // fill to capacity once to reach the full store case
      if (n == 100) for (int j = sb.held; j <= DEPTH; j++) send(OP_APP, pick_value(), 0);
    end
    cmd.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
